/* sv/sws_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sws_pkg
// Types and constants shared by the subset weight sum sampler files.
// ----------------------------------------------------------------------------
package sws_pkg;

	// Field widths fixed by the item format.
	localparam int SET_W    = 16;
	localparam int WEIGHT_W = 48;
	localparam int SUM_W    = 56;
	localparam int TOL_W    = 16;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SUM    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NO_HIT   = 2'd3;

	// One table entry as held in the memory.
	typedef struct packed {
		logic [SET_W-1:0]    ent_set;
		logic [WEIGHT_W-1:0] ent_weight;
	} entry_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_LOAD  = 5'b00100,
		ST_LOADW = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage
`default_nettype wire

/* sv/sws_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sws_mem
// Simple dual-port table memory: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module sws_mem #(
	parameter int DEPTH = 4096,
	parameter int DW    = 64
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [DW-1:0]            wr_data,
	input  wire                     rd_en,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DW-1:0]           rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* sv/subset_weight_sum_sampler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// subset_weight_sum_sampler
// Sorted table of set and weight pairs with subset sum and sample queries.
// ----------------------------------------------------------------------------
// Sequencing: a clear, a dropped load or a query on an empty table goes straight to
// the done state, a load into an empty table passes through the write state, and any
// other load or query walks the table, reading at most N entries, N being the count.
// Throughput: one item at a time; the next item is taken only after its result is
// registered and the sequencer is back in idle, the walk reading one entry per cycle on one read port.
// Reset clears the entry count, the tolerance and all control state; the table
// memory is not cleared, as only entries below the count are ever read.
module subset_weight_sum_sampler #(
	parameter int DEPTH = 4096
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// Configuration write channel.
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [sws_pkg::TOL_W-1:0]      cfg_data,
	// Input item channel.
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire [sws_pkg::KIND_W-1:0]     kind,
	input  wire [sws_pkg::SET_W-1:0]      entry_set,
	input  wire [sws_pkg::WEIGHT_W-1:0]   entry_weight,
	input  wire [sws_pkg::SET_W-1:0]      mask_u,
	input  wire [sws_pkg::SET_W-1:0]      mask_t,
	input  wire                           use_intersect,
	input  wire [sws_pkg::SUM_W-1:0]      target,
	// Result item channel.
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [sws_pkg::STATUS_W-1:0]  status,
	output logic [sws_pkg::SUM_W-1:0]     weight_sum,
	output logic [sws_pkg::SET_W-1:0]     chosen_set,
	output logic [sws_pkg::WEIGHT_W-1:0]  chosen_weight
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH) + 1;
	localparam int WW = sws_pkg::WEIGHT_W;
	localparam int SW = sws_pkg::SUM_W;
	localparam int TW = sws_pkg::TOL_W;
	localparam int XW = WW + CW;
	localparam int PW = WW + TW;
	localparam int LW = XW + TW;

	sws_pkg::state_t state_q;

	logic [CW-1:0] count_q;
	logic [TW-1:0] tol_q;

	// Captured item.
	logic [sws_pkg::KIND_W-1:0] kind_q;
	logic [sws_pkg::SET_W-1:0]  eset_q;
	logic [WW-1:0]              ew_q;
	logic [sws_pkg::SET_W-1:0]  u_q;
	logic [sws_pkg::SET_W-1:0]  t_q;
	logic                       ut_q;
	logic [SW-1:0]              target_q;

	// Walk control and pipeline.
	logic [CW-1:0]  idx_q;
	logic           iss_q;
	logic           v_s1;
	logic [AW-1:0]  idx_s1;
	logic           v_s2;
	logic [AW-1:0]  idx_s2;
	logic           m_s2;
	logic [sws_pkg::SET_W-1:0] set_s2;
	logic [WW-1:0]  w_s2;
	logic [XW-1:0]  wc_s2;
	logic [PW-1:0]  wt_s2;

	// Query accumulators.
	logic           found_q;
	logic           hit_q;
	logic           full_q;
	logic [SW-1:0]  acc_q;
	logic [PW-1:0]  rhs_q;
	logic [sws_pkg::SET_W-1:0] pick_set_q;
	logic [WW-1:0]  pick_w_q;
	logic [sws_pkg::SET_W-1:0] e0_set_q;
	logic [WW-1:0]  e0_w_q;

	logic           out_valid_q;

	// Memory ports.
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	sws_pkg::entry_t      rd_data;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	sws_pkg::entry_t      wr_data;

	sws_mem #(
		.DEPTH (DEPTH),
		.DW    ($bits(sws_pkg::entry_t))
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Combinational walk logic.
	logic            in_acc;
	logic            match_s1;
	logic            ld_shift;
	logic            load_end;
	logic [SW:0]     acc_sum;
	logic [SW-1:0]   acc_sat;
	logic            below;
	logic            last_s2;
	logic            sum_stop;
	logic            smp_hit;
	logic            scan_end;
	logic            out_load;
	sws_pkg::entry_t new_ent;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != sws_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == sws_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	assign new_ent.ent_set    = eset_q;
	assign new_ent.ent_weight = ew_q;

	// Reads issue while a walk runs; the index moves one entry each cycle.
	assign rd_en   = iss_q && ((state_q == sws_pkg::ST_SCAN) || (state_q == sws_pkg::ST_LOAD));
	assign rd_addr = idx_q[AW-1:0];

	// Subset test, and the intersection test when enabled.
	assign match_s1 = ((rd_data.ent_set & ~u_q) == '0) &&
		(!ut_q || ((rd_data.ent_set & t_q) != '0));

	// Insertion: entries lighter than the new one move up by one place.
	assign ld_shift = rd_data.ent_weight < ew_q;
	assign load_end = (state_q == sws_pkg::ST_LOAD) && v_s1 && !ld_shift;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = new_ent;
		if ((state_q == sws_pkg::ST_LOAD) && v_s1) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 + AW'(1);
			wr_data = ld_shift ? rd_data : new_ent;
		end else if (state_q == sws_pkg::ST_LOADW) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = new_ent;
		end
	end

	// Saturating running sum and the early-stop compare.
	assign acc_sum  = {1'b0, acc_q} + {{(SW + 1 - WW){1'b0}}, w_s2};
	assign acc_sat  = acc_sum[SW] ? {SW{1'b1}} : acc_sum[SW-1:0];
	assign below    = {wc_s2, {TW{1'b0}}} < {{(LW - PW){1'b0}}, rhs_q};
	assign last_s2  = {1'b0, idx_s2} == (count_q - CW'(1));
	assign sum_stop = v_s2 && m_s2 && found_q && (kind_q == sws_pkg::KIND_SUM) && below;
	assign smp_hit  = v_s2 && m_s2 && (kind_q == sws_pkg::KIND_SAMPLE) && (acc_sat > target_q);
	assign scan_end = (state_q == sws_pkg::ST_SCAN) && v_s2 && (sum_stop || smp_hit || last_s2);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q   <= kind;
			eset_q   <= entry_set;
			ew_q     <= entry_weight;
			u_q      <= mask_u;
			t_q      <= mask_t;
			ut_q     <= use_intersect;
			target_q <= target;
		end
	end

	// Pipeline payload: the scan stage registers both products per entry.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		idx_s2 <= idx_s1;
		m_s2   <= match_s1;
		set_s2 <= rd_data.ent_set;
		w_s2   <= rd_data.ent_weight;
		wc_s2  <= {{CW{1'b0}}, rd_data.ent_weight} * {{WW{1'b0}}, count_q};
		wt_s2  <= {{TW{1'b0}}, rd_data.ent_weight} * {{WW{1'b0}}, tol_q};
	end

	// Sequencer and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sws_pkg::ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			iss_q   <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			found_q <= 1'b0;
			hit_q   <= 1'b0;
			full_q  <= 1'b0;
			acc_q   <= '0;
		end else begin
			v_s1 <= rd_en && !scan_end && !load_end;
			v_s2 <= v_s1 && (state_q == sws_pkg::ST_SCAN) && !scan_end;
			case (state_q)
				sws_pkg::ST_IDLE: begin
					if (in_acc) begin
						found_q <= 1'b0;
						hit_q   <= 1'b0;
						full_q  <= 1'b0;
						acc_q   <= '0;
						case (kind)
							sws_pkg::KIND_CLEAR: begin
								count_q <= '0;
								state_q <= sws_pkg::ST_DONE;
							end
							sws_pkg::KIND_LOAD: begin
								if (count_q == CW'(DEPTH)) begin
									full_q  <= 1'b1;
									state_q <= sws_pkg::ST_DONE;
								end else if (count_q == '0) begin
									state_q <= sws_pkg::ST_LOADW;
								end else begin
									idx_q   <= count_q - CW'(1);
									iss_q   <= 1'b1;
									state_q <= sws_pkg::ST_LOAD;
								end
							end
							default: begin
								idx_q <= '0;
								if (count_q == '0) begin
									state_q <= sws_pkg::ST_DONE;
								end else begin
									iss_q   <= 1'b1;
									state_q <= sws_pkg::ST_SCAN;
								end
							end
						endcase
					end
				end
				sws_pkg::ST_SCAN: begin
					if (v_s2) begin
						if (idx_s2 == '0) begin
							e0_set_q <= set_s2;
							e0_w_q   <= w_s2;
						end
						if (m_s2 && !sum_stop) begin
							found_q    <= 1'b1;
							acc_q      <= acc_sat;
							pick_set_q <= set_s2;
							pick_w_q   <= w_s2;
							if (!found_q) begin
								rhs_q <= wt_s2;
							end
						end
						if (smp_hit) begin
							hit_q <= 1'b1;
						end
					end
					if (scan_end) begin
						iss_q   <= 1'b0;
						state_q <= sws_pkg::ST_DONE;
					end else if (iss_q) begin
						idx_q <= idx_q + CW'(1);
						if (idx_q == count_q - CW'(1)) begin
							iss_q <= 1'b0;
						end
					end
				end
				sws_pkg::ST_LOAD: begin
					if (load_end) begin
						iss_q   <= 1'b0;
						count_q <= count_q + CW'(1);
						state_q <= sws_pkg::ST_DONE;
					end else begin
						if (iss_q) begin
							if (idx_q == '0) begin
								iss_q <= 1'b0;
							end else begin
								idx_q <= idx_q - CW'(1);
							end
						end
						if (v_s1 && (idx_s1 == '0)) begin
							state_q <= sws_pkg::ST_LOADW;
						end
					end
				end
				sws_pkg::ST_LOADW: begin
					count_q <= count_q + CW'(1);
					state_q <= sws_pkg::ST_DONE;
				end
				sws_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= sws_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= sws_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Result assembly for the finished item.
	logic [sws_pkg::STATUS_W-1:0] res_status;
	logic [SW-1:0]                res_sum;
	logic [sws_pkg::SET_W-1:0]    res_set;
	logic [WW-1:0]                res_w;

	always_comb begin
		res_status = sws_pkg::STATUS_OK;
		res_sum    = '0;
		res_set    = '0;
		res_w      = '0;
		case (kind_q)
			sws_pkg::KIND_LOAD: begin
				if (full_q) begin
					res_status = sws_pkg::STATUS_FULL;
				end
			end
			sws_pkg::KIND_SUM: begin
				if (!found_q) begin
					res_status = sws_pkg::STATUS_NO_MATCH;
				end
				res_sum = acc_q;
			end
			sws_pkg::KIND_SAMPLE: begin
				if (!found_q) begin
					res_status = sws_pkg::STATUS_NO_MATCH;
				end else if (!hit_q) begin
					res_status = sws_pkg::STATUS_NO_HIT;
				end
				if (count_q != '0) begin
					res_set = found_q ? pick_set_q : e0_set_q;
					res_w   = found_q ? pick_w_q : e0_w_q;
				end
			end
			default: begin
				res_status = sws_pkg::STATUS_OK;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status        <= res_status;
			weight_sum    <= res_sum;
			chosen_set    <= res_set;
			chosen_weight <= res_w;
		end
	end

	// The entry count never passes the table depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond table depth");

	// Every entry read back during a walk lies below the entry count.
	a_read_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ({1'b0, idx_s1} < count_q))
		else $error("walk read an entry outside the table");

	// The scan stage only runs during a query walk.
	a_s2_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == sws_pkg::ST_SCAN))
		else $error("scan stage active outside a query");

	// A load that finishes through the write state has grown the table by exactly one entry.
	a_load_grows: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == sws_pkg::ST_LOADW) |=> (count_q == $past(count_q) + CW'(1))))
		else $error("load did not add one entry");

endmodule
`default_nettype wire

/* verif/tb_subset_weight_sum_sampler.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_subset_weight_sum_sampler
// Self-checking bench for the sorted weight table with subset sum and sample
// queries. A directed table runs first, then random load and query traffic. A local
// model of the table predicts every result that the directed table does not type in.
// Idling is random on both sides outside the closing phase, with one long output
// hold-off and a drain pause after each phase.
module tb_subset_weight_sum_sampler;

	localparam int DEPTH      = 4096;
	localparam int WDOG_LIMIT = 200000;
	localparam int N_RANDOM   = 124;
	localparam int KIND_W     = sws_pkg::KIND_W;
	localparam int SET_W      = sws_pkg::SET_W;
	localparam int WEIGHT_W   = sws_pkg::WEIGHT_W;
	localparam int SUM_W      = sws_pkg::SUM_W;
	localparam int TOL_W      = sws_pkg::TOL_W;
	localparam int STATUS_W   = sws_pkg::STATUS_W;
	localparam logic [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};

	// One input item and one result item.
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SET_W-1:0]    eset;
		logic [WEIGHT_W-1:0] ew;
		logic [SET_W-1:0]    u;
		logic [SET_W-1:0]    t;
		logic                use_t;
		logic [SUM_W-1:0]    tgt;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SUM_W-1:0]    wsum;
		logic [SET_W-1:0]    cset;
		logic [WEIGHT_W-1:0] cw;
	} res_t;

	// Directed row: the item, whether the result is typed in, and that result.
	typedef struct packed {
		req_t req;
		logic fixed;
		res_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [TOL_W-1:0] cfg_data = '0;
	logic cfg_ready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [KIND_W-1:0] kind = '0;
	logic [SET_W-1:0] entry_set = '0;
	logic [WEIGHT_W-1:0] entry_weight = '0;
	logic [SET_W-1:0] mask_u = '0;
	logic [SET_W-1:0] mask_t = '0;
	logic use_intersect = 1'b0;
	logic [SUM_W-1:0] target = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [SUM_W-1:0] weight_sum;
	logic [SET_W-1:0] chosen_set;
	logic [WEIGHT_W-1:0] chosen_weight;

	subset_weight_sum_sampler #(.DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind),
		.entry_set(entry_set), .entry_weight(entry_weight), .mask_u(mask_u),
		.mask_t(mask_t), .use_intersect(use_intersect), .target(target),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.weight_sum(weight_sum), .chosen_set(chosen_set),
		.chosen_weight(chosen_weight)
	);

	always #5 clk = ~clk;

	// Predictor state: a copy of the table and the tolerance.
	logic [SET_W-1:0]    tbl_set [DEPTH];
	logic [WEIGHT_W-1:0] tbl_w [DEPTH];
	int                  tbl_count = 0;
	logic [TOL_W-1:0]    tol = '0;

	res_t expected_results[$];
	row_t dir_rows[$];
	int   mismatches = 0;
	bit   calm = 1'b0;        // no idling at all in the closing stretch
	bit   hold_req = 1'b0;    // asks the receiver for one long hold-off
	int   idle_cycles = 0;

	function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a,
			logic [WEIGHT_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, b};
		return s[SUM_W] ? SUM_SAT : s[SUM_W-1:0];
	endfunction

	function automatic bit is_match(logic [SET_W-1:0] s, req_t r);
		return ((s & ~r.u) == '0) && (!r.use_t || ((s & r.t) != '0));
	endfunction

	// Works out the result of one item and updates the table copy.
	function automatic res_t predict_result(req_t r);
		res_t o;
		int p;
		bit found, hit;
		int pick;
		logic [WEIGHT_W-1:0] first;
		logic [127:0] lhs, rhs;
		o = '0;
		found = 0;
		hit = 0;
		pick = 0;
		first = '0;
		case (r.kind)
			sws_pkg::KIND_CLEAR: tbl_count = 0;
			sws_pkg::KIND_LOAD: begin
				if (tbl_count >= DEPTH) begin
					o.status = sws_pkg::STATUS_FULL;
				end else begin
					p = 0;
					while (p < tbl_count && tbl_w[p] >= r.ew) p++;
					for (int i = tbl_count; i > p; i--) begin
						tbl_set[i] = tbl_set[i-1];
						tbl_w[i] = tbl_w[i-1];
					end
					tbl_set[p] = r.eset;
					tbl_w[p] = r.ew;
					tbl_count++;
				end
			end
			sws_pkg::KIND_SUM: begin
				for (int i = 0; i < tbl_count; i++) begin
					if (!is_match(tbl_set[i], r)) continue;
					if (!found) begin
						found = 1;
						first = tbl_w[i];
						o.wsum = sat_sum('0, first);
					end else begin
						lhs = 128'(tbl_w[i]) * (128'(tbl_count) << 16);
						rhs = 128'(first) * 128'(tol);
						if (lhs < rhs) break;
						o.wsum = sat_sum(o.wsum, tbl_w[i]);
					end
				end
				if (!found) o.status = sws_pkg::STATUS_NO_MATCH;
			end
			default: begin
				for (int i = 0; i < tbl_count; i++) begin
					if (!is_match(tbl_set[i], r)) continue;
					found = 1;
					pick = i;
					o.wsum = sat_sum(o.wsum, tbl_w[i]);
					if (o.wsum > r.tgt) begin
						hit = 1;
						break;
					end
				end
				o.wsum = '0;
				if (!found) o.status = sws_pkg::STATUS_NO_MATCH;
				else if (!hit) o.status = sws_pkg::STATUS_NO_HIT;
				if (tbl_count > 0) begin
					o.cset = tbl_set[pick];
					o.cw = tbl_w[pick];
				end
			end
		endcase
		return o;
	endfunction

	function automatic req_t mk(logic [KIND_W-1:0] k, logic [SET_W-1:0] s,
			logic [WEIGHT_W-1:0] w, logic [SET_W-1:0] u, logic [SET_W-1:0] t,
			logic ut, logic [SUM_W-1:0] g);
		req_t r;
		r.kind = k; r.eset = s; r.ew = w; r.u = u; r.t = t; r.use_t = ut; r.tgt = g;
		return r;
	endfunction

	// Appends one row to the directed table.
	task automatic add_row(req_t r, bit fixed, res_t res);
		row_t rw;
		rw.req = r;
		rw.fixed = fixed;
		rw.res = res;
		dir_rows.insert(dir_rows.size(), rw);
	endtask

	// Random item, mostly loads and queries over a small set universe.
	function automatic req_t rand_req();
		req_t r;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		r.kind = (sel < 3) ? sws_pkg::KIND_CLEAR : (sel < 45) ? sws_pkg::KIND_LOAD :
			(sel < 72) ? sws_pkg::KIND_SUM : sws_pkg::KIND_SAMPLE;
		r.eset = ($urandom_range(0, 3) == 0) ? SET_W'($urandom) :
			SET_W'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0: r.ew = WEIGHT_W'({$urandom, $urandom});
			1: r.ew = WEIGHT_W'($urandom_range(0, 15));
			2: r.ew = {WEIGHT_W{1'b1}} - WEIGHT_W'($urandom_range(0, 3));
			default: r.ew = WEIGHT_W'($urandom_range(1, 4)) << 40;
		endcase
		r.u = ($urandom_range(0, 2) == 0) ? SET_W'($urandom) :
			(($urandom_range(0, 1) == 0) ? 16'hffff : 16'h00ff);
		r.t = SET_W'($urandom);
		r.use_t = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 2))
			0: r.tgt = SUM_W'({$urandom, $urandom});
			1: r.tgt = SUM_W'(WEIGHT_W'({$urandom, $urandom}));
			default: r.tgt = SUM_W'($urandom_range(0, 20));
		endcase
		return r;
	endfunction

	// Sends one item, records its expected result and waits for acceptance.
	// Valid stays high into the next item unless an idle burst follows.
	task automatic send_item(req_t r, bit fixed, res_t want);
		res_t p;
		p = predict_result(r);
		expected_results.insert(expected_results.size(), fixed ? want : p);
		in_valid <= 1'b1;
		kind <= r.kind; entry_set <= r.eset; entry_weight <= r.ew;
		mask_u <= r.u; mask_t <= r.t; use_intersect <= r.use_t; target <= r.tgt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_tol(logic [TOL_W-1:0] v);
		tol = v;
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result checker.
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, weight_sum, chosen_set, chosen_weight};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: st %0d/%0d sum %h/%h set %h/%h w %h/%h",
							want.status, got.status, want.wsum, got.wsum,
							want.cset, got.cset, want.cw, got.cw);
				end
			end
		end
	end

	// Receiver idling, including one long hold-off on request.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				n = 0;
				while (n < 400) begin
					@(posedge clk);
					n++;
				end
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7) - 1) @(posedge clk);
				@(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any handshake on the input, result or configuration channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		res_t z, nm;
		z = '0;
		nm = '0;
		nm.status = sws_pkg::STATUS_NO_MATCH;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty-table cases, extremes, ties and an all-ones sample target.
		add_row(mk(sws_pkg::KIND_SUM, '0, '0, 16'hffff, '0, 1'b0, '0), 1, nm);
		add_row(mk(sws_pkg::KIND_SAMPLE, '0, '0, 16'hffff, '0, 1'b0, '0), 1, nm);
		add_row(mk(sws_pkg::KIND_LOAD, 16'hffff, 48'hffffffffffff, '0, '0, 1'b0, '0),
			1, z);
		add_row(mk(sws_pkg::KIND_LOAD, 16'h0000, 48'h0, '0, '0, 1'b0, '0), 1, z);
		add_row(mk(sws_pkg::KIND_LOAD, 16'h0001, 48'hffffffffffff, '0, '0, 1'b0, '0),
			1, z);
		add_row(mk(sws_pkg::KIND_LOAD, 16'h0003, 48'h5, '0, '0, 1'b0, '0), 1, z);
		add_row(mk(sws_pkg::KIND_LOAD, 16'h0002, 48'h5, '0, '0, 1'b0, '0), 1, z);
		add_row(mk(sws_pkg::KIND_SUM, '0, '0, 16'hffff, '0, 1'b0, '0), 0, z);
		add_row(mk(sws_pkg::KIND_SUM, '0, '0, 16'h0003, 16'h0002, 1'b1, '0), 0, z);
		add_row(mk(sws_pkg::KIND_SUM, '0, '0, 16'h0000, 16'hffff, 1'b1, '0), 1, nm);
		add_row(mk(sws_pkg::KIND_SAMPLE, '0, '0, 16'hffff, '0, 1'b0, 56'd0), 0, z);
		add_row(mk(sws_pkg::KIND_SAMPLE, '0, '0, 16'hffff, '0, 1'b0,
			56'hffffffffffff), 0, z);
		add_row(mk(sws_pkg::KIND_SAMPLE, '0, '0, 16'hffff, '0, 1'b0, SUM_SAT), 0, z);
		add_row(mk(sws_pkg::KIND_SAMPLE, '0, '0, 16'h8000, 16'h8000, 1'b1, '0), 0, z);
		add_row(mk(sws_pkg::KIND_SAMPLE, '0, '0, 16'h0003, 16'h0001, 1'b1, 56'd5),
			0, z);
		add_row(mk(sws_pkg::KIND_CLEAR, 16'hffff, 48'hffffffffffff, 16'hffff,
			16'hffff, 1'b1, SUM_SAT), 1, z);
		add_row(mk(sws_pkg::KIND_SAMPLE, '0, '0, 16'hffff, '0, 1'b0, '0), 1, nm);
		foreach (dir_rows[i])
			send_item(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].res);
		wait_drain();

		// Random phases across several tolerance settings.
		write_tol(16'hffff);
		for (int i = 0; i < N_RANDOM / 4; i++) send_item(rand_req(), 0, z);
		wait_drain();
		write_tol(16'h8000);
		hold_req = 1'b1;
		for (int i = 0; i < N_RANDOM / 4; i++) send_item(rand_req(), 0, z);
		wait_drain();
		write_tol(16'h0001);
		for (int i = 0; i < N_RANDOM / 4; i++) send_item(rand_req(), 0, z);
		wait_drain();
		write_tol(16'd0);
		calm = 1'b1;
		for (int i = 0; i < N_RANDOM / 4; i++) send_item(rand_req(), 0, z);
		wait_drain();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
